FILE: hdl/tilt_to_level_averager_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tilt-to-level averager
// Concurrent assertion wrappers, one use per line in the asserting module.
// ----------------------------------------------------------------------------
`ifndef TILT_TO_LEVEL_AVERAGER_CORE_MACROS_SVH
`define TILT_TO_LEVEL_AVERAGER_CORE_MACROS_SVH

// Checked at every edge outside reset.
`define TLA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tla assertion failed");

// Checked at every edge, reset included.
`define TLA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tla reset assertion failed");

`endif

FILE: hdl/tla_pkg.sv
// ----------------------------------------------------------------------------
// Tilt-to-level averager package
// Field widths, register map, reset values and sequencer states.
// ----------------------------------------------------------------------------
package tla_pkg;

  localparam int unsigned ACC_W      = 16;
  localparam int unsigned HGT_W      = 18;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SCNT_W     = 5;
  localparam int unsigned MUL_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd2;

  localparam logic [15:0]       BASE_HEIGHT_RST  = 16'd8704;
  localparam logic [15:0]       ARM_LENGTH_RST   = 16'd8704;
  localparam logic [SCNT_W-1:0] SAMPLE_COUNT_RST = 5'd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_ARM2,
    ST_TGT,
    ST_LOAD,
    ST_BMUL,
    ST_BCMP,
    ST_SUM,
    ST_DPREP,
    ST_DIV,
    ST_OUT
  } tla_state_e;

endpackage

FILE: hdl/tilt_to_level_averager_core.sv
// ----------------------------------------------------------------------------
// Tilt-to-level averager core
// Integer height base + arm * y / |a| per sample, averaged over a block.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o   accel_x_i, accel_y_i, accel_z_i
//  out       output     out_valid_o / out_stall_i avg_height_o
//  cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One sample runs from acceptance back to ready through the squares, then a
// search over 16 result bits on the shared 32x32 multiplier, a multiply and a
// compare state per bit (skipped when y is zero). A block-closing sample adds the
// bit-serial divider, plus any wait for the output register to empty.
// Reset clears the sum, count and output valid and loads the default config.
// in_stall_o is high while a transaction is being worked on.
// ----------------------------------------------------------------------------
`include "tilt_to_level_averager_core_macros.svh"

module tilt_to_level_averager_core
  import tla_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [ACC_W-1:0]      accel_x_i,
  input  logic signed [ACC_W-1:0]      accel_y_i,
  input  logic signed [ACC_W-1:0]      accel_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [HGT_W-1:0]      avg_height_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = HGT_W + $clog2(MAX_SAMPLES);
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);
  localparam logic [8:0]  MAX_V  = 9'(MAX_SAMPLES);

  tla_state_e state_q, state_d;

  logic [15:0]             base_q, arm_q;
  logic [SCNT_W-1:0]       scnt_q;

  logic [ACC_W-1:0]        ax_q, ay_q, az_q, ax_d, ay_d, az_d;
  logic                    yneg_q, yneg_d, yzero_q, yzero_d;
  logic [2*MUL_W-1:0]      prod_q, prod_d;
  logic [MUL_W-1:0]        s_q, s_d, y2_q, y2_d;
  logic [2*MUL_W-1:0]      tgt_q, tgt_d;
  logic [15:0]             c_q, c_d, t_q, t_d;
  logic [MUL_W-1:0]        c2_q, c2_d, t2_q, t2_d;
  logic [3:0]              bit_q, bit_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [SUM_W-1:0]        dq_q, dq_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic                    dneg_q, dneg_d;
  logic [DCNT_W-1:0]       dcnt_q, dcnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [HGT_W-1:0]        out_q, out_d;

  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [8:0]              sc9, n9;
  logic [CNT_W-1:0]        n_eff, cnt_inc;
  logic                    pass;
  logic [15:0]             t_new;
  logic [MUL_W-1:0]        t2_new;
  logic [3:0]              nb;
  logic [HGT_W-1:0]        tval;
  logic signed [HGT_W-1:0] hgt;
  logic [SUM_W-1:0]        magu;
  logic [CNT_W:0]          r2;
  logic                    ge;
  logic [HGT_W-1:0]        qv;

  assign prod_d = mul_a * mul_b;

  always_comb begin
    sc9   = 9'(scnt_q);
    n9    = (scnt_q == '0) ? 9'd1 : ((sc9 > MAX_V) ? MAX_V : sc9);
    n_eff = CNT_W'(n9);
  end

  always_comb begin
    pass    = (c_q <= arm_q) && (prod_q <= tgt_q);
    t_new   = pass ? c_q : t_q;
    t2_new  = pass ? c2_q : t2_q;
    nb      = bit_q - 4'd1;
    tval    = HGT_W'(t_q);
    hgt     = $signed(HGT_W'(base_q) + (yneg_q ? (~tval + 1'b1) : tval));
    cnt_inc = cnt_q + 1'b1;
    magu    = sum_q[SUM_W-1] ? SUM_W'(~sum_q + 1'b1) : SUM_W'(sum_q);
    r2      = {rem_q, dq_q[SUM_W-1]};
    ge      = r2 >= {1'b0, n_eff};
    qv      = dq_q[HGT_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    az_d        = az_q;
    yneg_d      = yneg_q;
    yzero_d     = yzero_q;
    s_d         = s_q;
    y2_d        = y2_q;
    tgt_d       = tgt_q;
    c_d         = c_q;
    c2_d        = c2_q;
    t_d         = t_q;
    t2_d        = t2_q;
    bit_d       = bit_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    dneg_d      = dneg_q;
    dcnt_d      = dcnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_a       = '0;
    mul_b       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ax_d    = accel_x_i[ACC_W-1] ? ~accel_x_i + 1'b1 : accel_x_i;
          ay_d    = accel_y_i[ACC_W-1] ? ~accel_y_i + 1'b1 : accel_y_i;
          az_d    = accel_z_i[ACC_W-1] ? ~accel_z_i + 1'b1 : accel_z_i;
          yneg_d  = accel_y_i[ACC_W-1];
          yzero_d = (accel_y_i == '0);
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        mul_a   = MUL_W'(ax_q);
        mul_b   = MUL_W'(ax_q);
        state_d = ST_SQY;
      end
      ST_SQY: begin
        mul_a   = MUL_W'(ay_q);
        mul_b   = MUL_W'(ay_q);
        s_d     = prod_q[MUL_W-1:0];
        state_d = ST_SQZ;
      end
      ST_SQZ: begin
        mul_a   = MUL_W'(az_q);
        mul_b   = MUL_W'(az_q);
        s_d     = s_q + prod_q[MUL_W-1:0];
        y2_d    = prod_q[MUL_W-1:0];
        state_d = ST_ARM2;
      end
      ST_ARM2: begin
        mul_a   = MUL_W'(arm_q);
        mul_b   = MUL_W'(arm_q);
        s_d     = s_q + prod_q[MUL_W-1:0];
        state_d = ST_TGT;
      end
      ST_TGT: begin
        mul_a   = prod_q[MUL_W-1:0];
        mul_b   = y2_q;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        tgt_d   = prod_q;
        t_d     = '0;
        t2_d    = '0;
        c_d     = 16'h8000;
        c2_d    = 32'h4000_0000;
        bit_d   = 4'd15;
        state_d = yzero_q ? ST_SUM : ST_BMUL;
      end
      ST_BMUL: begin
        mul_a   = c2_q;
        mul_b   = s_q;
        state_d = ST_BCMP;
      end
      ST_BCMP: begin
        // c^2 for the next bit from t^2 + 2*t*2^b + 2^2b, no multiply needed
        t_d   = t_new;
        t2_d  = t2_new;
        c_d   = t_new | (16'd1 << nb);
        c2_d  = t2_new + (MUL_W'(t_new) << ({1'b0, nb} + 5'd1)) + (32'd1 << {nb, 1'b0});
        bit_d = nb;
        state_d = (bit_q == 4'd0) ? ST_SUM : ST_BMUL;
      end
      ST_SUM: begin
        sum_d = sum_q + SUM_W'(hgt);
        cnt_d = cnt_inc;
        state_d = (cnt_inc >= n_eff) ? ST_DPREP : ST_IDLE;
      end
      ST_DPREP: begin
        dq_d    = magu + SUM_W'(n_eff >> 1);
        dneg_d  = sum_q[SUM_W-1];
        rem_d   = '0;
        dcnt_d  = DCNT_W'(SUM_W);
        sum_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = ge ? CNT_W'(r2 - {1'b0, n_eff}) : CNT_W'(r2);
        dq_d   = {dq_q[SUM_W-2:0], ge};
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DCNT_W'(1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_d       = dneg_q ? (~qv + 1'b1) : qv;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      base_q      <= BASE_HEIGHT_RST;
      arm_q       <= ARM_LENGTH_RST;
      scnt_q      <= SAMPLE_COUNT_RST;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BASE_HEIGHT:  base_q <= cfg_data_i;
          REG_ARM_LENGTH:   arm_q  <= cfg_data_i;
          REG_SAMPLE_COUNT: scnt_q <= cfg_data_i[SCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    az_q    <= az_d;
    yneg_q  <= yneg_d;
    yzero_q <= yzero_d;
    prod_q  <= prod_d;
    s_q     <= s_d;
    y2_q    <= y2_d;
    tgt_q   <= tgt_d;
    c_q     <= c_d;
    c2_q    <= c2_d;
    t_q     <= t_d;
    t2_q    <= t2_d;
    bit_q   <= bit_d;
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    dneg_q  <= dneg_d;
    dcnt_q  <= dcnt_d;
    out_q   <= out_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign avg_height_o = $signed(out_q);

  `TLA_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  `TLA_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(MAX_SAMPLES))
  `TLA_ASSERT(a_term_le_arm, clk_i, rst_ni, (state_q == ST_SUM) |-> (t_q <= arm_q))
  `TLA_ASSERT(a_out_hold, clk_i, rst_ni, (state_q == ST_OUT) && out_valid_q && out_stall_i |=> (state_q == ST_OUT))
  `TLA_ASSERT_ALWAYS(a_reset_out, clk_i, !rst_ni |=> !out_valid_o)

endmodule

FILE: tb/sv/tilt_to_level_averager_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt-to-level averager testbench
// Drives accelerometer samples under random idling on both channels, predicts
// each block average from its own copy of the configuration and running sum,
// and checks every avg_height transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tilt_to_level_averager_core_test
  import tla_pkg::*;
();

  localparam int unsigned             MAX_SAMPLES  = 16;
  localparam logic [CFG_IDX_W-1:0]    REG_UNMAPPED = 2'd3;
  localparam int                      IDLE_CYCLES  = 100;
  localparam int                      CYCLE_LIMIT  = 2000000;
  localparam int                      HOLD_CYCLES  = 3000;
  localparam int                      TARGET_ITEMS = 1800;

  typedef struct packed {
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] y;
    logic [ACC_W-1:0] z;
  } tilt_sample_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0]        cfg_data_i   = '0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_stall_o;
  logic signed [ACC_W-1:0]      accel_x_i    = '0;
  logic signed [ACC_W-1:0]      accel_y_i    = '0;
  logic signed [ACC_W-1:0]      accel_z_i    = '0;
  logic                         out_valid_o;
  logic                         out_stall_i  = 1'b0;
  logic signed [HGT_W-1:0]      avg_height_o;

  // predictor state
  logic [15:0]                  cur_base;
  logic [15:0]                  cur_arm;
  logic [SCNT_W-1:0]            cur_count;
  longint                       level_sum;
  int                           level_samples;

  tilt_sample_t                 sample_q[$];
  logic signed [HGT_W-1:0]      level_avg_q[$];
  tilt_sample_t                 tx_next;

  int                           samples_open  = 0;
  int                           samples_sent  = 0;
  int                           samples_in    = 0;
  int                           avgs_checked  = 0;
  int                           cfg_writes    = 0;
  int                           err_cnt       = 0;
  int                           tx_gap        = 0;
  int                           rx_gap        = 0;
  int                           hold_left     = 0;
  int                           cycles        = 0;
  logic                         idle_on       = 1'b1;
  logic                         hold_go       = 1'b0;
  logic                         hold_done     = 1'b0;

  tilt_to_level_averager_core #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .avg_height_o (avg_height_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sample_height(logic signed [ACC_W-1:0] ax,
                                           logic signed [ACC_W-1:0] ay,
                                           logic signed [ACC_W-1:0] az);
    longint            sx, sy, sz, h;
    longint unsigned   y2, mag2, arm, target, t, c;
    sx   = longint'(ax);
    sy   = longint'(ay);
    sz   = longint'(az);
    arm  = 64'(cur_arm);
    y2   = $unsigned(sy * sy);
    mag2 = sx * sx + y2 + sz * sz;
    h    = longint'(cur_base);
    if (mag2 != 0 && sy != 0) begin
      target = arm * arm * y2;
      t = 0;
      for (int b = 15; b >= 0; b--) begin
        c = t | (64'd1 << b);
        if (c <= arm && c * c * mag2 <= target) t = c;
      end
      h = (sy < 0) ? h - longint'(t) : h + longint'(t);
    end
    return h;
  endfunction

  function automatic longint block_len();
    longint n;
    n = longint'(cur_count);
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    return n;
  endfunction

  task automatic accumulate_sample(logic signed [ACC_W-1:0] ax,
                                   logic signed [ACC_W-1:0] ay,
                                   logic signed [ACC_W-1:0] az);
    longint n, mag, q;
    level_sum += sample_height(ax, ay, az);
    level_samples++;
    n = block_len();
    if (level_samples >= n) begin
      mag = (level_sum < 0) ? -level_sum : level_sum;
      q   = (mag + n / 2) / n;
      level_avg_q.push_back(HGT_W'((level_sum < 0) ? -q : q));
      level_sum     = 0;
      level_samples = 0;
    end
  endtask

  // ------------------------------------------------------------------- driver
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        accumulate_sample(accel_x_i, accel_y_i, accel_z_i);
        samples_open--;
        samples_in++;
      end
      if (in_valid_i && in_stall_o) begin
        // payload held while stalled
      end else if (tx_gap != 0) begin
        tx_gap     <= tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (sample_q.size() != 0) begin
        tx_next    = sample_q.pop_front();
        accel_x_i  <= tx_next.x;
        accel_y_i  <= tx_next.y;
        accel_z_i  <= tx_next.z;
        in_valid_i <= 1'b1;
        tx_gap     <= (idle_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------- receiver and check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_gap      <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap      <= rx_gap - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      rx_gap      <= gap_len();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (level_avg_q.size() == 0) begin
        $error("avg_height transaction with no average pending: actual %0d", avg_height_o);
        err_cnt++;
      end else begin
        if (avg_height_o !== level_avg_q[0]) begin
          $error("avg_height mismatch: expected %0d, actual %0d",
                 level_avg_q[0], avg_height_o);
          err_cnt++;
        end
        void'(level_avg_q.pop_front());
        avgs_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d averages pending", cycles, level_avg_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_BASE_HEIGHT:  cur_base  = data;
      REG_ARM_LENGTH:   cur_arm   = data;
      REG_SAMPLE_COUNT: cur_count = data[SCNT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_sample(logic [ACC_W-1:0] x, logic [ACC_W-1:0] y,
                             logic [ACC_W-1:0] z);
    tilt_sample_t s;
    s.x = x;
    s.y = y;
    s.z = z;
    samples_open++;
    samples_sent++;
    sample_q.push_back(s);
  endtask

  function automatic logic [ACC_W-1:0] extreme_axis();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  task automatic push_random(int cnt);
    logic [ACC_W-1:0] x, y, z;
    for (int i = 0; i < cnt; i++) begin
      x = ACC_W'($urandom);
      y = ACC_W'($urandom);
      z = ACC_W'($urandom);
      case ($urandom_range(0, 9))
        5, 6: begin
          x = ACC_W'($urandom_range(0, 255) - 128);
          y = ACC_W'($urandom_range(0, 255) - 128);
          z = ACC_W'($urandom_range(0, 255) - 128);
        end
        7: begin
          if ($urandom_range(0, 1)) x = '0;
          else z = '0;
        end
        8: begin
          x = extreme_axis();
          y = extreme_axis();
          z = extreme_axis();
        end
        9: begin
          if ($urandom_range(0, 1)) y = '0;
          else begin
            x = '0;
            z = '0;
          end
        end
        default: ;
      endcase
      push_sample(x, y, z);
    end
  endtask

  task automatic wait_idle();
    while (samples_open != 0 || level_avg_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    logic [15:0] d;
    d = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd16;
      2:       return 16'd1;
      3:       return 16'($urandom_range(17, 31));
      4:       return d;
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  initial begin
    cur_base      = BASE_HEIGHT_RST;
    cur_arm       = ARM_LENGTH_RST;
    cur_count     = SAMPLE_COUNT_RST;
    level_sum     = 0;
    level_samples = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset configuration: zero vector, axis extremes, gravity on y
    push_sample(16'h0000, 16'h0000, 16'h0000);
    push_sample(16'h0000, 16'h7FFF, 16'h0000);
    push_sample(16'h0000, 16'h8000, 16'h0000);
    push_sample(16'h7FFF, 16'h0000, 16'h0000);
    push_sample(16'h8000, 16'h0000, 16'h8000);
    push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_sample(16'h8000, 16'h8000, 16'h8000);
    push_sample(16'h0000, 16'h0001, 16'h0000);
    push_sample(16'h0000, 16'hFFFF, 16'h0000);
    push_sample(16'h0001, 16'h0001, 16'h0001);
    push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(16'h7FFF, 16'h8000, 16'h7FFF);
    push_sample(16'h0000, 16'h4000, 16'h0000);
    push_sample(16'd100,  -16'sd200, 16'h4000);
    wait_idle();

    // unmapped index is ignored; count zero acts as one; output extremes
    cfg_write(REG_UNMAPPED, 16'h1234);
    cfg_write(REG_BASE_HEIGHT, 16'h0000);
    cfg_write(REG_ARM_LENGTH, 16'hFFFF);
    cfg_write(REG_SAMPLE_COUNT, 16'd0);
    push_sample(16'h0000, 16'h8000, 16'h0000);
    push_sample(16'h0000, 16'h7FFF, 16'h0000);
    push_sample(16'h0000, 16'h0000, 16'h0000);
    wait_idle();
    cfg_write(REG_BASE_HEIGHT, 16'hFFFF);
    cfg_write(REG_SAMPLE_COUNT, 16'd1);
    push_sample(16'h0000, 16'h7FFF, 16'h0000);
    wait_idle();

    // count lowered below the samples already taken
    cfg_write(REG_SAMPLE_COUNT, 16'd16);
    push_random(7);
    wait_idle();
    cfg_write(REG_SAMPLE_COUNT, 16'd2);
    push_random(1);
    wait_idle();

    // oversized count clamps; largest positive and negative sums
    cfg_write(REG_SAMPLE_COUNT, 16'd31);
    for (int i = 0; i < 16; i++) push_sample(16'h0000, 16'h7FFF, 16'h0000);
    wait_idle();
    cfg_write(REG_BASE_HEIGHT, 16'h0000);
    for (int i = 0; i < 16; i++) push_sample(16'h0000, 16'h8000, 16'h0000);
    wait_idle();

    // rounding ties away from zero
    cfg_write(REG_ARM_LENGTH, 16'd3);
    cfg_write(REG_SAMPLE_COUNT, 16'd2);
    push_sample(16'h0000, 16'h0001, 16'h0000);
    push_sample(16'h0000, 16'h0000, 16'h0000);
    push_sample(16'h0000, 16'hFFFF, 16'h0000);
    push_sample(16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // long output hold with one average per sample: the block backs up
    cfg_write(REG_BASE_HEIGHT, 16'hFFFF);
    cfg_write(REG_ARM_LENGTH, 16'hFFFF);
    cfg_write(REG_SAMPLE_COUNT, 16'd1);
    @(posedge clk_i);
    idle_on <= 1'b0;
    push_random(40);
    @(posedge clk_i);
    hold_go <= 1'b1;
    wait_idle();
    idle_on <= 1'b1;

    while (samples_sent < TARGET_ITEMS) begin
      @(posedge clk_i);
      idle_on <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) cfg_write(REG_BASE_HEIGHT, pick_length());
      if ($urandom_range(0, 1)) cfg_write(REG_ARM_LENGTH, pick_length());
      if ($urandom_range(0, 1)) cfg_write(REG_SAMPLE_COUNT, pick_count());
      if ($urandom_range(0, 7) == 0) cfg_write(REG_UNMAPPED, CFG_DATA_W'($urandom));
      push_random($urandom_range(10, 120));
      wait_idle();
    end

    $display("%0d samples accepted, %0d averages checked, %0d register writes",
             samples_in, avgs_checked, cfg_writes);
    $display("covered zero vector, clamped counts, mid-block count changes,");
    $display("and a long output hold");
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
